@@ design/positional_list_engine_macros.svh @@
// Assertion macros shared by the positional list engine.
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH

// Check that an antecedent implies a consequent in the same cycle.
`define PLE_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("positional list engine: same-cycle check failed");

// Check that an antecedent implies a consequent in the next cycle.
`define PLE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("positional list engine: next-cycle check failed");

`endif

@@ design/ple_pkg.sv @@
// Package: sizes, codes and command/status types of the positional list engine.
`timescale 1ns / 1ps
`default_nettype none
package ple_pkg;

  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;
  localparam int FIELD_W    = 32;
  localparam int MODE_W     = 2;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  typedef enum logic [MODE_W-1:0] {
    MODE_INS = 2'd0,
    MODE_RM  = 2'd1,
    MODE_RD  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    RA_POS_IN, RA_CNT_M1, RA_W_P1, RA_W_P2, RA_W_M2
  } ra_sel_e;

  typedef enum logic [1:0] {
    WA_POS_IN, WA_POS_Q, WA_W
  } wa_sel_e;

  typedef enum logic [1:0] {
    WD_VAL_IN, WD_VAL_Q, WD_RDATA
  } wd_sel_e;

  typedef enum logic [1:0] {
    PTR_HOLD, PTR_INC, PTR_DEC
  } ptr_op_e;

  typedef enum logic [1:0] {
    CNT_HOLD, CNT_INC, CNT_DEC
  } cnt_op_e;

  typedef enum logic [1:0] {
    DS_ZERO, DS_RDATA, DS_HELD
  } ds_sel_e;

  typedef struct packed {
    logic    ld_op;
    ra_sel_e ra_sel;
    logic    we;
    wa_sel_e wa_sel;
    wd_sel_e wd_sel;
    ptr_op_e ptr_op;
    logic    ld_held;
    logic    finish;
    cnt_op_e cnt_op;
    ds_sel_e ds_sel;
  } cmd_t;

  typedef struct packed {
    status_e chk;
    logic    is_ins;
    logic    is_rd;
    logic    ins_at_end;
    logic    rm_none;
    logic    rm_last;
    logic    ins_last;
  } sts_t;

endpackage
`default_nettype wire

@@ design/positional_list_engine.sv @@
// Top level: positional list engine, controller plus datapath.
// Sequence: an error or an append finishes straight from idle; a read passes the read
// state; remove shifts count - 1 - position entries down; insert shifts count - position up.
// Throughput: one request at a time; the next start is taken in the cycle done is high.
// Shift cost is one entry per cycle through the single write port of the entry memory.
// Reset: the list is empty, busy and done are low; entry memory is not cleared.
// done_o marks each result for one cycle; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
`include "positional_list_engine_macros.svh"
module positional_list_engine (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [ple_pkg::MODE_W-1:0]          mode_i,
  input  logic [ple_pkg::CNT_W-1:0]           position_i,
  input  logic signed [ple_pkg::FIELD_W-1:0]  item_value_i,
  output logic                                done_o,
  output logic signed [ple_pkg::FIELD_W-1:0]  data_out_o,
  output logic [1:0]                          status_o,
  output logic [ple_pkg::CNT_W-1:0]           entry_count_o
);
  import ple_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ple_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  ple_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .mode_i        (mode_i),
    .position_i    (position_i),
    .item_value_i  (item_value_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .data_out_o    (data_out_o),
    .status_o      (status_o),
    .entry_count_o (entry_count_o)
  );

  `PLE_ASSERT_NEXT(a_transfer_progress, start && !busy, busy || done_o)
  `PLE_ASSERT_SAME(a_count_moves_on_done, !$stable(entry_count_o), done_o)
  `PLE_ASSERT_SAME(a_full_at_capacity, done_o && status_o == ST_FULL,
                   entry_count_o == CNT_W'(CAPACITY))
  `PLE_ASSERT_SAME(a_count_bounded, 1'b1, entry_count_o <= CNT_W'(CAPACITY))

endmodule
`default_nettype wire

@@ design/ple_ctrl.sv @@
// Controller: sequences one list request through check, read and shift steps.
`timescale 1ns / 1ps
`default_nettype none
module ple_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  ple_pkg::sts_t sts_i,
  output ple_pkg::cmd_t cmd_o,
  output logic          busy_o,
  output logic          done_o
);
  import ple_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_RM_HEAD, S_RM_MOVE, S_INS_MOVE, S_INS_PUT
  } state_e;

  state_e state_q, state_d;
  logic   done_q;

  always_comb begin
    cmd_o   = '{ld_op: 1'b0, ra_sel: RA_POS_IN, we: 1'b0, wa_sel: WA_W,
                wd_sel: WD_RDATA, ptr_op: PTR_HOLD, ld_held: 1'b0, finish: 1'b0,
                cnt_op: CNT_HOLD, ds_sel: DS_ZERO};
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.ld_op = 1'b1;
          if (sts_i.chk != ST_OK) begin
            cmd_o.finish = 1'b1;
          end else if (sts_i.is_ins) begin
            if (sts_i.ins_at_end) begin
              // append: no entries to move
              cmd_o.we     = 1'b1;
              cmd_o.wa_sel = WA_POS_IN;
              cmd_o.wd_sel = WD_VAL_IN;
              cmd_o.finish = 1'b1;
              cmd_o.cnt_op = CNT_INC;
            end else begin
              cmd_o.ra_sel = RA_CNT_M1;
              state_d      = S_INS_MOVE;
            end
          end else begin
            cmd_o.ra_sel = RA_POS_IN;
            state_d      = sts_i.is_rd ? S_RD : S_RM_HEAD;
          end
        end
      end
      S_RD: begin
        cmd_o.finish = 1'b1;
        cmd_o.ds_sel = DS_RDATA;
        state_d      = S_IDLE;
      end
      S_RM_HEAD: begin
        cmd_o.ld_held = 1'b1;
        if (sts_i.rm_none) begin
          cmd_o.finish = 1'b1;
          cmd_o.ds_sel = DS_RDATA;
          cmd_o.cnt_op = CNT_DEC;
          state_d      = S_IDLE;
        end else begin
          cmd_o.ra_sel = RA_W_P1;
          state_d      = S_RM_MOVE;
        end
      end
      S_RM_MOVE: begin
        // shift down: entry above moves into the hole
        cmd_o.we     = 1'b1;
        cmd_o.wa_sel = WA_W;
        cmd_o.wd_sel = WD_RDATA;
        if (sts_i.rm_last) begin
          cmd_o.finish = 1'b1;
          cmd_o.ds_sel = DS_HELD;
          cmd_o.cnt_op = CNT_DEC;
          state_d      = S_IDLE;
        end else begin
          cmd_o.ra_sel = RA_W_P2;
          cmd_o.ptr_op = PTR_INC;
        end
      end
      S_INS_MOVE: begin
        // shift up from the tail toward the insert point
        cmd_o.we     = 1'b1;
        cmd_o.wa_sel = WA_W;
        cmd_o.wd_sel = WD_RDATA;
        if (sts_i.ins_last) begin
          state_d = S_INS_PUT;
        end else begin
          cmd_o.ra_sel = RA_W_M2;
          cmd_o.ptr_op = PTR_DEC;
        end
      end
      S_INS_PUT: begin
        cmd_o.we     = 1'b1;
        cmd_o.wa_sel = WA_POS_Q;
        cmd_o.wd_sel = WD_VAL_Q;
        cmd_o.finish = 1'b1;
        cmd_o.cnt_op = CNT_INC;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= cmd_o.finish;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule
`default_nettype wire

@@ design/ple_datapath.sv @@
// Datapath: entry memory, count, shift pointer, request checks and result registers.
`timescale 1ns / 1ps
`default_nettype none
module ple_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [ple_pkg::MODE_W-1:0]          mode_i,
  input  logic [ple_pkg::CNT_W-1:0]           position_i,
  input  logic signed [ple_pkg::FIELD_W-1:0]  item_value_i,
  input  ple_pkg::cmd_t                       cmd_i,
  output ple_pkg::sts_t                       sts_o,
  output logic signed [ple_pkg::FIELD_W-1:0]  data_out_o,
  output logic [1:0]                          status_o,
  output logic [ple_pkg::CNT_W-1:0]           entry_count_o
);
  import ple_pkg::*;

  logic signed [DATA_WIDTH-1:0] mem_q [CAPACITY];
  logic signed [DATA_WIDTH-1:0] rdata_q;
  logic signed [DATA_WIDTH-1:0] val_q, held_q, in_val, wdata;
  logic signed [FIELD_W-1:0]    res_data_q;
  logic [IDX_W-1:0]             w_q, pos_q, raddr, waddr, pos_in;
  logic [CNT_W-1:0]             cnt_q;
  status_e                      stat_q, chk;
  logic                         is_ins, is_rm, is_rd;

  assign pos_in = position_i[IDX_W-1:0];
  assign in_val = DATA_WIDTH'(item_value_i);
  assign is_ins = (mode_i == MODE_INS);
  assign is_rm  = (mode_i == MODE_RM);
  assign is_rd  = (mode_i == MODE_RD);

  always_comb begin
    priority if (is_ins) begin
      priority if (position_i > cnt_q)                  chk = ST_BADPOS;
      else if (cnt_q == CNT_W'(CAPACITY))              chk = ST_FULL;
      else                                              chk = ST_OK;
    end else if (is_rm || is_rd) begin
      priority if (cnt_q == '0)                         chk = ST_EMPTY;
      else if (position_i >= cnt_q)                     chk = ST_BADPOS;
      else                                              chk = ST_OK;
    end else begin
      chk = ST_BADPOS;
    end
  end

  assign sts_o.chk        = chk;
  assign sts_o.is_ins     = is_ins;
  assign sts_o.is_rd      = is_rd;
  assign sts_o.ins_at_end = (position_i == cnt_q);
  assign sts_o.rm_none    = (CNT_W'(w_q) == cnt_q - CNT_W'(1));
  assign sts_o.rm_last    = (CNT_W'(w_q) == cnt_q - CNT_W'(2));
  assign sts_o.ins_last   = (w_q == pos_q + IDX_W'(1));

  always_comb begin
    unique case (cmd_i.ra_sel)
      RA_POS_IN: raddr = pos_in;
      RA_CNT_M1: raddr = IDX_W'(cnt_q - CNT_W'(1));
      RA_W_P1:   raddr = w_q + IDX_W'(1);
      RA_W_P2:   raddr = w_q + IDX_W'(2);
      RA_W_M2:   raddr = w_q - IDX_W'(2);
      default:   raddr = pos_in;
    endcase
    unique case (cmd_i.wa_sel)
      WA_POS_IN: waddr = pos_in;
      WA_POS_Q:  waddr = pos_q;
      WA_W:      waddr = w_q;
      default:   waddr = w_q;
    endcase
    unique case (cmd_i.wd_sel)
      WD_VAL_IN: wdata = in_val;
      WD_VAL_Q:  wdata = val_q;
      WD_RDATA:  wdata = rdata_q;
      default:   wdata = rdata_q;
    endcase
  end

  // entry memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_op) begin
      pos_q <= pos_in;
      val_q <= in_val;
      w_q   <= is_ins ? IDX_W'(cnt_q) : pos_in;
    end else begin
      unique case (cmd_i.ptr_op)
        PTR_HOLD: w_q <= w_q;
        PTR_INC:  w_q <= w_q + IDX_W'(1);
        PTR_DEC:  w_q <= w_q - IDX_W'(1);
        default:  w_q <= w_q;
      endcase
    end
    if (cmd_i.ld_held) begin
      held_q <= rdata_q;
    end
    if (cmd_i.finish) begin
      unique case (cmd_i.ds_sel)
        DS_ZERO:  res_data_q <= '0;
        DS_RDATA: res_data_q <= FIELD_W'(rdata_q);
        DS_HELD:  res_data_q <= FIELD_W'(held_q);
        default:  res_data_q <= '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      stat_q <= ST_OK;
    end else begin
      if (cmd_i.ld_op) begin
        stat_q <= chk;
      end
      if (cmd_i.finish) begin
        unique case (cmd_i.cnt_op)
          CNT_HOLD: cnt_q <= cnt_q;
          CNT_INC:  cnt_q <= cnt_q + CNT_W'(1);
          CNT_DEC:  cnt_q <= cnt_q - CNT_W'(1);
          default:  cnt_q <= cnt_q;
        endcase
      end
    end
  end

  assign data_out_o    = res_data_q;
  assign status_o      = stat_q;
  assign entry_count_o = cnt_q;

endmodule
`default_nettype wire
